[rtl/core/waveform_window_peak_centroid_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the waveform window peak centroid block
// Clocked implication checks, disabled while the reset is active.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_WINDOW_PEAK_CENTROID_ASSERT_SVH
`define WAVEFORM_WINDOW_PEAK_CENTROID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/wwpc_pkg.sv]
// ----------------------------------------------------------------------------
// wwpc_pkg
// Constants, widths and the sequencer state type of the window peak block.
// ----------------------------------------------------------------------------
package wwpc_pkg;

	localparam int MAX_WINDOW  = 16;
	localparam int MAX_SAMPLES = 64;
	localparam int FRAC_BITS   = 8;

	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 5;
	localparam int SUM_W    = 20;
	localparam int WSUM_W   = 27;
	localparam int START_W  = 6;
	localparam int TIME_W   = 14;

	localparam int RING_AW = $clog2(MAX_WINDOW);
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W   = $clog2(MAX_SAMPLES);
	localparam int LEFT_W  = $clog2(MAX_WINDOW + 1);
	localparam int DIVC_W  = $clog2(TIME_W + 1);
	localparam int DIVD_W  = WSUM_W + FRAC_BITS;
	localparam int REM_W   = DIVD_W - TIME_W;

	localparam int OUT_BITS = SUM_W + START_W + TIME_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(6);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DSET,
		ST_DIV,
		ST_OUT
	} wwpc_state_t;

endpackage

[rtl/core/waveform_window_peak_centroid.sv]
// ----------------------------------------------------------------------------
// waveform_window_peak_centroid
// Sliding-window peak integration with a centroid time, one sample per beat.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one unsigned 16-bit waveform sample per beat
// in s_tdata, and s_tlast marks the last sample of a pixel. The output stream
// delivers one beat per pixel, once its last sample has been
// processed. Its tdata holds the peak window sum, the start index of that
// window, the centroid time with 8 fractional bits, and the too-long flag.
// The window width is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, as the block itself does not enforce this.
// Throughput: each sample is written into a 16-entry ring memory, and a single
// adder/multiplier pair then walks the current window one entry per cycle
// through the registered ring read port. A sample therefore occupies the
// block until the walk ends once a full window exists; s_tready is low
// meanwhile. At the end of a pixel, a restoring divider takes a setup step
// and, unless the peak sum is zero, produces one quotient bit per cycle;
// the result is then loaded into the output register.
// The result is held in an output register; the next pixel's samples are
// accepted while it waits. If the receiver stalls and a second result is
// ready, the block holds it and takes no input until the register is free.
// Reset clears the sequencer, the pixel state and the output valid, and sets
// the window width to 6. The ring needs no clearing, since only entries
// written in the current pixel are read.
// ----------------------------------------------------------------------------
module waveform_window_peak_centroid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wwpc_pkg::WIN_W-1:0]    cfg_wdata,  // window_size
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wwpc_pkg::SAMPLE_W-1:0] s_tdata,    // sample
	input  logic                          s_tlast,    // last_sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// peak_sum[19:0], peak_start[25:20], peak_time[39:26], too_long[40], zeros
	output logic [wwpc_pkg::OUT_W-1:0]    m_tdata
);
	import wwpc_pkg::*;

	wwpc_state_t state_q, state_n;

	// Configuration and pixel state.
	logic [WIN_W-1:0]    win_cfg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_W-1:0]    best_sum_q;
	logic [WSUM_W-1:0]   best_wsum_q;
	logic [START_W-1:0]  best_start_q;
	logic                ovf_q;
	logic                last_q;

	// Window walk: read index, reads left, accumulators.
	logic [IDX_W-1:0]    idx_q;
	logic [LEFT_W-1:0]   left_q;
	logic [SUM_W-1:0]    acc_sum_q;
	logic [WSUM_W-1:0]   acc_wsum_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [SAMPLE_W-1:0] rdata_s1;

	// The sample ring.
	logic [SAMPLE_W-1:0] ring_q [MAX_WINDOW];

	// Divider.
	logic [REM_W-1:0]    rem_q;
	logic [TIME_W-1:0]   quot_q;
	logic [DIVC_W-1:0]   divc_q;

	// Output register.
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// Combinational helpers.
	logic                s_acc;
	logic                has_room;
	logic [WIN_W-1:0]    win_eff;
	logic [CNT_W-1:0]    cnt_inc;
	logic                win_full;
	logic [CNT_W-1:0]    start_full;
	logic                walk_done;
	logic                out_free;
	logic [DIVD_W-1:0]   dividend;
	logic [REM_W:0]      trial;
	logic [REM_W:0]      trial_diff;
	logic                trial_ok;
	logic [OUT_BITS-1:0] out_pack;

	assign s_acc     = s_tvalid && s_tready;
	assign has_room  = cnt_q < CNT_W'(MAX_SAMPLES);
	assign cnt_inc   = cnt_q + CNT_W'(1);

	// A zero width counts as one, widths above the ring depth saturate.
	always_comb begin
		priority if (win_cfg_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (win_cfg_q > WIN_W'(MAX_WINDOW)) begin
			win_eff = WIN_W'(MAX_WINDOW);
		end else begin
			win_eff = win_cfg_q;
		end
	end

	assign win_full   = cnt_inc >= CNT_W'(win_eff);
	assign start_full = cnt_inc - CNT_W'(win_eff);
	assign walk_done  = (left_q == '0) && !vld_s1;
	assign out_free   = !m_tvalid_q || m_tready;

	assign dividend   = {best_wsum_q, FRAC_BITS'(0)};
	assign trial      = {rem_q, quot_q[TIME_W-1]};
	assign trial_diff = trial - (REM_W + 1)'(best_sum_q);
	assign trial_ok   = trial >= (REM_W + 1)'(best_sum_q);

	assign out_pack = {ovf_q, quot_q, best_start_q, best_sum_q};

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (has_room && win_full) begin
						state_n = ST_ACC;
					end else if (s_tlast) begin
						state_n = ST_DSET;
					end
				end
			end
			ST_ACC: begin
				if (walk_done) begin
					state_n = last_q ? ST_DSET : ST_IDLE;
				end
			end
			ST_DSET: begin
				state_n = (best_sum_q == '0) ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				if (divc_q == DIVC_W'(1)) begin
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = m_tvalid_q;
		m_tdata  = m_tdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			win_cfg_q <= cfg_wdata;
		end
	end

	// Ring write on an accepted sample with room, registered read during the walk.
	always_ff @(posedge clk) begin
		if (s_acc && has_room) begin
			ring_q[cnt_q[RING_AW-1:0]] <= s_tdata;
		end
		rdata_s1 <= ring_q[idx_q[RING_AW-1:0]];
		idx_s1   <= idx_q;
	end

	// Sequencer datapath: window walk, peak tracking, division, output load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			best_sum_q   <= '0;
			best_wsum_q  <= '0;
			best_start_q <= '0;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
			idx_q        <= '0;
			left_q       <= '0;
			acc_sum_q    <= '0;
			acc_wsum_q   <= '0;
			vld_s1       <= 1'b0;
			rem_q        <= '0;
			quot_q       <= '0;
			divc_q       <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						last_q <= s_tlast;
						if (has_room) begin
							cnt_q      <= cnt_inc;
							idx_q      <= start_full[IDX_W-1:0];
							// Reads are only scheduled once a whole window exists.
							left_q     <= win_full ? LEFT_W'(win_eff) : '0;
							acc_sum_q  <= '0;
							acc_wsum_q <= '0;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_ACC: begin
					if (left_q != '0) begin
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + IDX_W'(1);
						left_q <= left_q - LEFT_W'(1);
					end
					if (vld_s1) begin
						acc_sum_q  <= acc_sum_q + SUM_W'(rdata_s1);
						acc_wsum_q <= acc_wsum_q + WSUM_W'(rdata_s1) * WSUM_W'(idx_s1);
					end
					// The first strictly greatest window wins.
					if (walk_done && (acc_sum_q > best_sum_q)) begin
						best_sum_q   <= acc_sum_q;
						best_wsum_q  <= acc_wsum_q;
						best_start_q <= START_W'(idx_q - IDX_W'(win_eff));
					end
				end
				ST_DSET: begin
					// The quotient fits in TIME_W bits, so the upper dividend
					// bits start out as the partial remainder.
					rem_q  <= dividend[DIVD_W-1:TIME_W];
					quot_q <= (best_sum_q == '0) ? '0 : dividend[TIME_W-1:0];
					divc_q <= DIVC_W'(TIME_W);
				end
				ST_DIV: begin
					rem_q  <= trial_ok ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
					quot_q <= {quot_q[TIME_W-2:0], trial_ok};
					divc_q <= divc_q - DIVC_W'(1);
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q   <= 1'b1;
						m_tdata_q    <= OUT_W'(out_pack);
						cnt_q        <= '0;
						best_sum_q   <= '0;
						best_wsum_q  <= '0;
						best_start_q <= '0;
						ovf_q        <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

`include "waveform_window_peak_centroid_assert.svh"

	`WWPC_ASSERT_SAME(a_div_nonzero, state_q == ST_DIV, best_sum_q != '0, "division by a zero peak sum")
	`WWPC_ASSERT_SAME(a_walk_in_acc, left_q != '0, state_q == ST_ACC, "window reads pending outside the walk")
	`WWPC_ASSERT_SAME(a_idle_quiet, s_tready, !vld_s1, "ring read in flight while taking a sample")
	`WWPC_ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && out_free, m_tvalid && (cnt_q == '0), "result not loaded or pixel not cleared")

endmodule
